/* rtl/core/fta_pkg.sv */
// ----------------------------------------------------------------------------
// fta_pkg
// Shared types, widths and constants of the face target aim-and-fire block.
// ----------------------------------------------------------------------------
package fta_pkg;

    // Field widths
    localparam int COL_W      = 11;
    localparam int ROW_W      = 10;
    localparam int POS_W      = 16;
    localparam int TIME_W     = 32;
    localparam int CNT_W      = 8;
    localparam int COOL_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Datapath widths
    localparam int DIST_W  = 25;   // exact squared distance
    localparam int OFS_X_W = 13;   // mouth column minus target, signed
    localparam int OFS_Y_W = 12;   // mouth row minus target, signed
    localparam int MAG_X_W = 12;
    localparam int MAG_Y_W = 11;
    localparam int NX_W    = 18;
    localparam int NY_W    = 16;
    localparam int Q_W     = 12;   // step offset magnitude
    localparam int V_W     = 13;   // signed step offset

    // Scaling: 700/1280 = 35/64, 500/720 = 25/36
    localparam logic [5:0]  SCALE_X_NUM   = 6'd35;
    localparam int          SCALE_X_SHIFT = 6;
    localparam logic [4:0]  SCALE_Y_NUM   = 5'd25;
    // floor(n/36) = (n * 233017) >> 23 for n < 58254
    localparam logic [17:0] RECIP_36      = 18'd233017;
    localparam int          RECIP_36_SH   = 23;
    localparam int          PROD_Y_W      = NY_W + 19;

    localparam logic [Q_W-1:0]   DEADBAND_STEPS = 12'd2;
    localparam logic [CNT_W-1:0] CNT_MAX        = 8'hFF;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_X          = 3'd0,
        REG_TARGET_Y          = 3'd1,
        REG_MAX_FACE_WIDTH    = 3'd2,
        REG_MAX_FACE_HEIGHT   = 3'd3,
        REG_FIRE_ENABLE       = 3'd4,
        REG_TRACK_WHILE_ARMED = 3'd5,
        REG_MIN_ON_TARGET     = 3'd6,
        REG_FIRE_COOLDOWN_MS  = 3'd7
    } cfg_reg_t;

    // Result kinds
    localparam logic ACT_MOVE = 1'b0;
    localparam logic ACT_FIRE = 1'b1;

    typedef struct packed {
        logic                     face_valid;
        logic [COL_W-1:0]         face_x;
        logic [ROW_W-1:0]         face_y;
        logic [COL_W-1:0]         face_width;
        logic [ROW_W-1:0]         face_height;
        logic                     frame_last;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [TIME_W-1:0]        time_ms;
    } face_item_t;

    typedef struct packed {
        logic                     action_kind;
        logic signed [POS_W-1:0]  move_x;
        logic signed [POS_W-1:0]  move_y;
    } aim_item_t;

    // floor(h/6) for a 10-bit value, by reciprocal multiply
    function automatic logic [7:0] div6(input logic [ROW_W-1:0] h);
        logic [23:0] p;
        p = {14'd0, h} * 24'd2731;
        return p[21:14];
    endfunction

endpackage

/* rtl/core/face_target_aim_and_fire.sv */
// ----------------------------------------------------------------------------
// face_target_aim_and_fire
// Picks the face nearest the target per frame and issues a move or fire.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one face rectangle per item, with turret position
//   and a millisecond timestamp; frame_last marks the frame's final item.
//   out_valid/out_ready carry at most one result per frame: a move to a new
//   saturated position, or a fire.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the eight settings; cfg_ready
//   is always high. Write them only while the block is idle.
// Timing:
//   The input register (stage 0) is followed by stages 1 to 5 and the
//   output register, which drives out_valid. One item per cycle is
//   accepted when nothing stalls; stages collapse bubbles, so input keeps
//   flowing while a result waits until the pipeline is full.
// Reset:
//   Settings return to their defaults, the retained face, on-target counter
//   and last fire time clear, and the pipeline empties.
// Stall:
//   If out_ready is low the result holds; later frame-end items back up stage
//   by stage and in_ready drops once the items behind them reach the input.
// ----------------------------------------------------------------------------
module face_target_aim_and_fire
    import fta_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  face_item_t            in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output aim_item_t             out_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_reg_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration
    logic [COL_W-1:0]  target_x_reg;
    logic [ROW_W-1:0]  target_y_reg;
    logic [COL_W-1:0]  max_w_reg;
    logic [ROW_W-1:0]  max_h_reg;
    logic              fire_en_reg;
    logic              track_reg;
    logic [CNT_W-1:0]  min_on_reg;
    logic [COOL_W-1:0] cooldown_reg;

    // Frame and aim state
    logic              best_valid_reg;
    logic [COL_W-1:0]  best_x_reg;
    logic [ROW_W-1:0]  best_y_reg;
    logic [COL_W-1:0]  best_w_reg;
    logic [ROW_W-1:0]  best_h_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [TIME_W-1:0] last_fire_reg;

    // Stage 0: input register
    logic              v0_reg;
    face_item_t        s0_reg;

    // Stage 1: distance
    logic              v1_reg;
    logic              keep1_reg;
    logic [DIST_W-1:0] dist1_reg;
    face_item_t        s1_reg;

    // Stage 2: selected face at frame end
    logic                    v2_reg;
    logic [COL_W-1:0]        x2_reg;
    logic [ROW_W-1:0]        y2_reg;
    logic [COL_W-1:0]        w2_reg;
    logic [ROW_W-1:0]        h2_reg;
    logic signed [POS_W-1:0] px2_reg, py2_reg;
    logic [TIME_W-1:0]       t2_reg;

    // Stage 3: pixel offset
    logic                      v3_reg;
    logic signed [OFS_X_W-1:0] ox3_reg;
    logic signed [OFS_Y_W-1:0] oy3_reg;
    logic signed [POS_W-1:0]   px3_reg, py3_reg;
    logic [TIME_W-1:0]         t3_reg;

    // Stage 4: scaled magnitudes
    logic                    v4_reg;
    logic                    sx4_reg, sy4_reg;
    logic [NX_W-1:0]         nx4_reg;
    logic [NY_W-1:0]         ny4_reg;
    logic signed [POS_W-1:0] px4_reg, py4_reg;
    logic [TIME_W-1:0]       t4_reg;

    // Stage 5: step offsets
    logic                    v5_reg;
    logic                    sx5_reg, sy5_reg;
    logic [Q_W-1:0]          qx5_reg, qy5_reg;
    logic signed [POS_W-1:0] px5_reg, py5_reg;
    logic [TIME_W-1:0]       t5_reg;

    // Output register
    logic       out_valid_reg;
    aim_item_t  out_reg;

    // Load enables, from the output backward
    logic ld_out, ld5, ld4, ld3, ld2, ld1, ld0;

    // Stage 1 logic
    logic [COL_W:0]            cx;
    logic [ROW_W:0]            cy;
    logic signed [COL_W+1:0]   dx;
    logic signed [ROW_W+1:0]   dy;
    logic [COL_W:0]            adx;
    logic [ROW_W:0]            ady;
    logic [2*COL_W+1:0]        sqx;
    logic [2*ROW_W+1:0]        sqy;
    logic                      keep0;

    // Stage 2 logic
    logic             take;
    logic             sel_valid;
    logic [COL_W-1:0] sel_x, sel_w;
    logic [ROW_W-1:0] sel_y, sel_h;

    // Stage 3 logic
    logic [OFS_X_W-1:0] mx;
    logic [OFS_Y_W-1:0] my;
    logic [ROW_W+1:0]   h3;
    logic [7:0]         h6;

    // Stage 4 logic
    logic [MAG_X_W-1:0] ax;
    logic [MAG_Y_W-1:0] ay;

    // Stage 5 logic
    logic [PROD_Y_W-1:0] prod_y;

    // Decision logic
    logic                    off_target;
    logic [CNT_W-1:0]        cnt_base;
    logic [CNT_W-1:0]        cnt_inc;
    logic [CNT_W-1:0]        cnt_next;
    logic [TIME_W-1:0]       elapsed;
    logic                    fire;
    logic                    emit;
    logic signed [V_W-1:0]   vx, vy;
    logic signed [POS_W:0]   sum_x, sum_y;
    logic signed [POS_W-1:0] sat_x, sat_y;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign ld_out   = !out_valid_reg || out_ready;
    assign ld5      = !v5_reg || ld_out;
    assign ld4      = !v4_reg || ld5;
    assign ld3      = !v3_reg || ld4;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign ld0      = !v0_reg || ld1;
    assign in_ready = ld0;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg <= 11'd588;
            target_y_reg <= 10'd296;
            max_w_reg    <= 11'd110;
            max_h_reg    <= 10'd110;
            fire_en_reg  <= 1'b0;
            track_reg    <= 1'b1;
            min_on_reg   <= 8'd5;
            cooldown_reg <= 16'd5000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TARGET_X:          target_x_reg <= cfg_data[COL_W-1:0];
                REG_TARGET_Y:          target_y_reg <= cfg_data[ROW_W-1:0];
                REG_MAX_FACE_WIDTH:    max_w_reg    <= cfg_data[COL_W-1:0];
                REG_MAX_FACE_HEIGHT:   max_h_reg    <= cfg_data[ROW_W-1:0];
                REG_FIRE_ENABLE:       fire_en_reg  <= cfg_data[0];
                REG_TRACK_WHILE_ARMED: track_reg    <= cfg_data[0];
                REG_MIN_ON_TARGET:     min_on_reg   <= cfg_data[CNT_W-1:0];
                REG_FIRE_COOLDOWN_MS:  cooldown_reg <= cfg_data[COOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage 1: size filter and squared distance of the face center
    always_comb
    begin
        keep0 = s0_reg.face_valid && (s0_reg.face_width <= max_w_reg)
                && (s0_reg.face_height <= max_h_reg);
        cx  = {1'b0, s0_reg.face_x} + {2'b0, s0_reg.face_width[COL_W-1:1]};
        cy  = {1'b0, s0_reg.face_y} + {2'b0, s0_reg.face_height[ROW_W-1:1]};
        dx  = $signed({1'b0, cx}) - $signed({2'b0, target_x_reg});
        dy  = $signed({1'b0, cy}) - $signed({2'b0, target_y_reg});
        adx = dx[COL_W+1] ? (COL_W+1)'(0) - dx[COL_W:0] : dx[COL_W:0];
        ady = dy[ROW_W+1] ? (ROW_W+1)'(0) - dy[ROW_W:0] : dy[ROW_W:0];
        sqx = adx * adx;
        sqy = ady * ady;
    end

    // Stage 2: nearest face, earlier kept on ties
    always_comb
    begin
        take      = keep1_reg && (!best_valid_reg || dist1_reg < best_dist_reg);
        sel_valid = best_valid_reg || take;
        sel_x     = take ? s1_reg.face_x      : best_x_reg;
        sel_y     = take ? s1_reg.face_y      : best_y_reg;
        sel_w     = take ? s1_reg.face_width  : best_w_reg;
        sel_h     = take ? s1_reg.face_height : best_h_reg;
    end

    // Stage 3: mouth center and offset from target
    always_comb
    begin
        h6 = div6(h2_reg);
        h3 = {2'b0, h2_reg} + {1'b0, h2_reg, 1'b0};
        // w/4 + (w/2)/2 is twice w/4
        mx = {2'b0, x2_reg} + {3'b0, w2_reg[COL_W-1:2], 1'b0};
        my = {2'b0, y2_reg} + {2'b0, h3[ROW_W+1:2]} + {5'b0, h6[7:1]};
    end

    // Stage 4: magnitudes times the scale numerators
    always_comb
    begin
        ax = ox3_reg[OFS_X_W-1] ? MAG_X_W'(0) - ox3_reg[MAG_X_W-1:0] : ox3_reg[MAG_X_W-1:0];
        ay = oy3_reg[OFS_Y_W-1] ? MAG_Y_W'(0) - oy3_reg[MAG_Y_W-1:0] : oy3_reg[MAG_Y_W-1:0];
    end

    // Stage 5: divide by 64 and by 36
    assign prod_y = ny4_reg * RECIP_36;

    // Decision: deadband, on-target counter, cooldown, saturated move
    always_comb
    begin
        off_target = (qx5_reg > DEADBAND_STEPS) || (qy5_reg > DEADBAND_STEPS);
        cnt_base   = fire_en_reg ? count_reg : '0;
        cnt_inc    = (cnt_base < CNT_MAX) ? cnt_base + 8'd1 : cnt_base;
        elapsed    = t5_reg - last_fire_reg;
        fire       = !off_target && (cnt_inc > min_on_reg)
                     && (elapsed > {16'd0, cooldown_reg});
        if (off_target || fire)
            cnt_next = '0;
        else
            cnt_next = cnt_inc;
        emit  = fire || track_reg || (cnt_next == '0);
        vx    = sx5_reg ? V_W'(0) - $signed({1'b0, qx5_reg}) : $signed({1'b0, qx5_reg});
        vy    = sy5_reg ? V_W'(0) - $signed({1'b0, qy5_reg}) : $signed({1'b0, qy5_reg});
        sum_x = {px5_reg[POS_W-1], px5_reg} + {{(POS_W+1-V_W){vx[V_W-1]}}, vx};
        sum_y = {py5_reg[POS_W-1], py5_reg} + {{(POS_W+1-V_W){vy[V_W-1]}}, vy};
        if (sum_x[POS_W] != sum_x[POS_W-1])
            sat_x = sum_x[POS_W] ? 16'sh8000 : 16'sh7FFF;
        else
            sat_x = sum_x[POS_W-1:0];
        if (sum_y[POS_W] != sum_y[POS_W-1])
            sat_y = sum_y[POS_W] ? 16'sh8000 : 16'sh7FFF;
        else
            sat_y = sum_y[POS_W-1:0];
    end

    // Control state: valid bits, retained face valid, counter, fire time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg         <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            v5_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            best_valid_reg <= 1'b0;
            count_reg      <= '0;
            last_fire_reg  <= '0;
        end
        else
        begin
            if (ld0)
                v0_reg <= in_valid;
            if (ld1)
                v1_reg <= v0_reg;
            if (ld2)
                v2_reg <= v1_reg && s1_reg.frame_last && sel_valid;
            if (ld3)
                v3_reg <= v2_reg;
            if (ld4)
                v4_reg <= v3_reg;
            if (ld5)
                v5_reg <= v4_reg;
            if (ld_out)
                out_valid_reg <= v5_reg && emit;
            // retained face: cleared at frame end
            if (v1_reg && ld2)
            begin
                if (s1_reg.frame_last)
                    best_valid_reg <= 1'b0;
                else if (take)
                    best_valid_reg <= 1'b1;
            end
            if (v5_reg && ld_out)
            begin
                count_reg <= cnt_next;
                if (fire)
                    last_fire_reg <= t5_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ld0)
            s0_reg <= in_item;
        if (ld1)
        begin
            s1_reg    <= s0_reg;
            keep1_reg <= keep0;
            dist1_reg <= {1'b0, sqx} + {3'b0, sqy};
        end
        if (v1_reg && ld2 && take)
        begin
            best_x_reg    <= s1_reg.face_x;
            best_y_reg    <= s1_reg.face_y;
            best_w_reg    <= s1_reg.face_width;
            best_h_reg    <= s1_reg.face_height;
            best_dist_reg <= dist1_reg;
        end
        if (ld2)
        begin
            x2_reg  <= sel_x;
            y2_reg  <= sel_y;
            w2_reg  <= sel_w;
            h2_reg  <= sel_h;
            px2_reg <= s1_reg.pos_x;
            py2_reg <= s1_reg.pos_y;
            t2_reg  <= s1_reg.time_ms;
        end
        if (ld3)
        begin
            ox3_reg <= $signed(mx) - $signed({2'b0, target_x_reg});
            oy3_reg <= $signed(my) - $signed({2'b0, target_y_reg});
            px3_reg <= px2_reg;
            py3_reg <= py2_reg;
            t3_reg  <= t2_reg;
        end
        if (ld4)
        begin
            sx4_reg <= ox3_reg[OFS_X_W-1];
            sy4_reg <= oy3_reg[OFS_Y_W-1];
            nx4_reg <= {6'b0, ax} * {12'b0, SCALE_X_NUM};
            ny4_reg <= {5'b0, ay} * {11'b0, SCALE_Y_NUM};
            px4_reg <= px3_reg;
            py4_reg <= py3_reg;
            t4_reg  <= t3_reg;
        end
        if (ld5)
        begin
            sx5_reg <= sx4_reg;
            sy5_reg <= sy4_reg;
            qx5_reg <= nx4_reg[SCALE_X_SHIFT +: Q_W];
            qy5_reg <= prod_y[RECIP_36_SH +: Q_W];
            px5_reg <= px4_reg;
            py5_reg <= py4_reg;
            t5_reg  <= t4_reg;
        end
        if (ld_out && v5_reg)
        begin
            if (fire)
            begin
                out_reg.action_kind <= ACT_FIRE;
                out_reg.move_x      <= '0;
                out_reg.move_y      <= '0;
            end
            else
            begin
                out_reg.action_kind <= ACT_MOVE;
                out_reg.move_x      <= sat_x;
                out_reg.move_y      <= sat_y;
            end
        end
    end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench of face_target_aim_and_fire: a software copy of the aim logic
// predicts the move or fire item for every frame, and each result item is
// compared with it. Directed frames cover the field extremes, size limits,
// ties, saturation and fire timing. Random frames with random settings follow,
// mostly aimed close to the target so the counter and cooldown are exercised.
// ----------------------------------------------------------------------------
module tb
    import fta_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FOV_X          = 700;
    localparam int FOV_Y          = 500;
    localparam int IMG_W          = 1280;
    localparam int IMG_H          = 720;
    localparam int AIM_DEADBAND   = 2;
    localparam int PIPE_SLACK     = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    // DUT signals
    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    face_item_t            in_item;
    logic                  out_valid;
    logic                  out_ready;
    aim_item_t             out_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_reg_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Settings as last written
    int m_target_x;
    int m_target_y;
    int m_max_w;
    int m_max_h;
    bit m_fire_enable;
    bit m_track_armed;
    int m_min_on;
    int m_cooldown;

    // Predicted block state
    bit                best_valid;
    int                best_x;
    int                best_y;
    int                best_w;
    int                best_h;
    longint            best_dist;
    int                on_target;
    logic [TIME_W-1:0] last_fire;

    aim_item_t aim_expected[$];
    int        err_count;
    bit        idle_on;
    int        ready_hold;
    int        quiet_cycles;
    logic [TIME_W-1:0] clock_ms;

    face_target_aim_and_fire u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int clamp16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Track the nearest face; at frame end work out the aim decision
    function automatic void predict_aim(input face_item_t it);
        int        fx;
        int        fy;
        int        fw;
        int        fh;
        int        px;
        int        py;
        int        mx;
        int        my;
        int        vx;
        int        vy;
        longint    dx;
        longint    dy;
        longint    sq_dist;
        bit        fired;
        aim_item_t res;
        logic [TIME_W-1:0] since;
        fx = it.face_x;
        fy = it.face_y;
        fw = it.face_width;
        fh = it.face_height;
        px = it.pos_x;
        py = it.pos_y;
        fired = 1'b0;
        if (it.face_valid && fw <= m_max_w && fh <= m_max_h)
        begin
            dx = fx + fw / 2 - m_target_x;
            dy = fy + fh / 2 - m_target_y;
            sq_dist = dx * dx + dy * dy;
            // strict compare: the earlier face wins a tie
            if (!best_valid || sq_dist < best_dist)
            begin
                best_valid = 1'b1;
                best_x = fx;
                best_y = fy;
                best_w = fw;
                best_h = fh;
                best_dist = sq_dist;
            end
        end
        if (!it.frame_last)
            return;
        if (best_valid)
        begin
            mx = best_x + best_w / 4 + (best_w / 2) / 2;
            my = best_y + (9 * best_h) / 12 + (best_h / 6) / 2;
            vx = (mx - m_target_x) * FOV_X / IMG_W;
            vy = (my - m_target_y) * FOV_Y / IMG_H;
            if (!m_fire_enable)
                on_target = 0;
            if ((vx < 0 ? -vx : vx) > AIM_DEADBAND || (vy < 0 ? -vy : vy) > AIM_DEADBAND)
                on_target = 0;
            else
            begin
                if (on_target < 255)
                    on_target++;
                since = it.time_ms - last_fire;
                if (on_target > m_min_on && since > 32'(m_cooldown))
                begin
                    on_target = 0;
                    last_fire = it.time_ms;
                    fired = 1'b1;
                end
            end
            if (fired)
            begin
                res.action_kind = ACT_FIRE;
                res.move_x = '0;
                res.move_y = '0;
                aim_expected.push_back(res);
            end
            else if (m_track_armed || on_target == 0)
            begin
                res.action_kind = ACT_MOVE;
                res.move_x = 16'(clamp16(px + vx));
                res.move_y = 16'(clamp16(py + vy));
                aim_expected.push_back(res);
            end
        end
        best_valid = 1'b0;
        best_x = 0;
        best_y = 0;
        best_w = 0;
        best_h = 0;
        best_dist = 0;
    endfunction

    function automatic face_item_t face_item(input bit v, input int x, input int y,
                                             input int w, input int h, input bit last,
                                             input int px, input int py,
                                             input logic [TIME_W-1:0] t);
        face_item_t it;
        it.face_valid  = v;
        it.face_x      = x[COL_W-1:0];
        it.face_y      = y[ROW_W-1:0];
        it.face_width  = w[COL_W-1:0];
        it.face_height = h[ROW_W-1:0];
        it.frame_last  = last;
        it.pos_x       = px[POS_W-1:0];
        it.pos_y       = py[POS_W-1:0];
        it.time_ms     = t;
        return it;
    endfunction

    // Send one item, with an optional idle burst first
    task automatic send_face(input face_item_t it);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_aim(it);
    endtask

    // Stop sending, wait for every result, then let the pipeline drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (aim_expected.size() != 0)
            @(posedge clk);
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TARGET_X:          m_target_x = value & 32'h7FF;
            REG_TARGET_Y:          m_target_y = value & 32'h3FF;
            REG_MAX_FACE_WIDTH:    m_max_w = value & 32'h7FF;
            REG_MAX_FACE_HEIGHT:   m_max_h = value & 32'h3FF;
            REG_FIRE_ENABLE:       m_fire_enable = value[0];
            REG_TRACK_WHILE_ARMED: m_track_armed = value[0];
            REG_MIN_ON_TARGET:     m_min_on = value & 32'hFF;
            REG_FIRE_COOLDOWN_MS:  m_cooldown = value & 32'hFFFF;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_config(input int tx, input int ty, input int mw, input int mh,
                                input int fe, input int tw, input int mn, input int cd);
        write_reg(REG_TARGET_X, tx);
        write_reg(REG_TARGET_Y, ty);
        write_reg(REG_MAX_FACE_WIDTH, mw);
        write_reg(REG_MAX_FACE_HEIGHT, mh);
        write_reg(REG_FIRE_ENABLE, fe);
        write_reg(REG_TRACK_WHILE_ARMED, tw);
        write_reg(REG_MIN_ON_TARGET, mn);
        write_reg(REG_FIRE_COOLDOWN_MS, cd);
    endtask

    function automatic int pick_pos();
        case ($urandom_range(0, 7))
            0: return 32767;
            1: return -32768;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // Rectangle whose mouth lands within +-spread pixels of the target
    function automatic void aimed_rect(input int spread, output int x, output int y,
                                       output int w, output int h);
        w = $urandom_range(0, (m_max_w < 160) ? m_max_w : 160);
        h = $urandom_range(0, (m_max_h < 160) ? m_max_h : 160);
        x = m_target_x - (w / 4 + (w / 2) / 2)
            + int'($urandom_range(0, 2 * spread)) - spread;
        y = m_target_y - ((9 * h) / 12 + (h / 6) / 2)
            + int'($urandom_range(0, 2 * spread)) - spread;
        x = (x < 0) ? 0 : ((x > 1279) ? 1279 : x);
        y = (y < 0) ? 0 : ((y > 719) ? 719 : y);
    endfunction

    // One frame of n faces (zero gives an empty frame)
    task automatic send_frame(input int n_faces, input int aimed_pct, input int spread,
                              input int step_max);
        int x;
        int y;
        int w;
        int h;
        int n;
        bit v;
        if ($urandom_range(0, 9) == 0)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, step_max);
        n = (n_faces == 0) ? 1 : n_faces;
        for (int i = 0; i < n; i++)
        begin
            v = (n_faces != 0) && ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 99) < aimed_pct)
                aimed_rect(spread, x, y, w, h);
            else
            begin
                x = $urandom_range(0, 1279);
                y = $urandom_range(0, 719);
                if ($urandom_range(0, 7) == 0)
                begin
                    w = $urandom_range(0, 1280);
                    h = $urandom_range(0, 720);
                end
                else
                begin
                    w = $urandom_range(0, (m_max_w + 20 > 1280) ? 1280 : m_max_w + 20);
                    h = $urandom_range(0, (m_max_h + 20 > 720) ? 720 : m_max_h + 20);
                end
            end
            send_face(face_item(v, x, y, w, h, i == n - 1, pick_pos(), pick_pos(),
                                clock_ms));
        end
    endtask

    // Defaults after reset: size limits, ties, nearest pick, saturation
    task automatic test_reset_defaults();
        // empty frame gives nothing
        send_face(face_item(0, 588, 296, 50, 50, 1, 0, 0, 100));
        // smallest face in the corner
        send_face(face_item(1, 0, 0, 0, 0, 1, 0, 0, 200));
        // largest face is dropped, frame ends empty
        send_face(face_item(1, 1279, 719, 1280, 720, 1, 0, 0, 300));
        // just over each limit dropped, exactly at the limit kept
        send_face(face_item(1, 100, 100, 111, 50, 0, 0, 0, 400));
        send_face(face_item(1, 100, 100, 50, 111, 0, 0, 0, 400));
        send_face(face_item(1, 1169, 609, 110, 110, 1, 1000, -1000, 400));
        // equal distance: the first face stays
        send_face(face_item(1, 500, 246, 100, 100, 0, 0, 0, 500));
        send_face(face_item(1, 510, 256, 80, 80, 1, 0, 0, 500));
        // nearest face in the middle of the frame
        send_face(face_item(1, 0, 0, 50, 50, 0, 0, 0, 600));
        send_face(face_item(1, 560, 260, 50, 50, 0, 0, 0, 600));
        send_face(face_item(1, 1200, 600, 60, 60, 1, 7, 7, 600));
        // empty item inside a frame and as its last item
        send_face(face_item(1, 100, 100, 20, 20, 0, 0, 0, 700));
        send_face(face_item(0, 588, 296, 0, 0, 0, 0, 0, 700));
        send_face(face_item(0, 0, 0, 0, 0, 1, -5, 5, 700));
        // position sums saturate both ways
        send_face(face_item(1, 1229, 669, 50, 50, 1, 32767, 32767, 800));
        send_face(face_item(1, 0, 0, 50, 50, 1, -32768, -32768, 900));
        // on target with fire disabled keeps moving
        for (int i = 0; i < 3; i++)
            send_face(face_item(1, 538, 213, 100, 100, 1, 12, -12, 10000 + i));
        wait_idle();
    endtask

    // Every register at its extremes
    task automatic test_config_extremes();
        apply_config(0, 0, 1280, 720, 1, 0, 0, 65535);
        send_face(face_item(1, 1279, 719, 1280, 720, 1, 100, -100, 1000));
        send_face(face_item(1, 0, 0, 0, 0, 1, 5, 5, 70000));
        send_face(face_item(1, 0, 0, 0, 0, 1, 5, 5, 70001));
        // cooldown exactly elapsed does not fire, one more ms does
        send_face(face_item(1, 0, 0, 0, 0, 1, 5, 5, 135535));
        send_face(face_item(1, 0, 0, 0, 0, 1, 5, 5, 135536));
        send_face(face_item(1, 1279, 719, 1280, 720, 1, -7, 7, 135600));
        wait_idle();
        apply_config(1279, 719, 0, 0, 0, 1, 255, 0);
        send_face(face_item(1, 1279, 719, 0, 0, 1, 32767, -32768, 5));
        send_face(face_item(1, 1279, 719, 1, 0, 0, 0, 0, 6));
        send_face(face_item(1, 1279, 719, 0, 1, 0, 0, 0, 6));
        send_face(face_item(1, 0, 0, 0, 0, 1, 0, 0, 6));
        wait_idle();
    endtask

    // Fire timing around the 32-bit time wrap, armed and tracking
    task automatic test_fire_timing();
        clock_ms = 32'hFFFF_F000;
        apply_config($urandom_range(100, 1100), $urandom_range(100, 600), 160, 160,
                     1, 0, 2, 300);
        for (int i = 0; i < 40; i++)
            send_frame(1, 90, 6, 150);
        wait_idle();
        // disabled fire still fires when zero on-target frames are asked for
        apply_config($urandom_range(100, 1100), $urandom_range(100, 600), 160, 160,
                     0, 1, 0, 0);
        for (int i = 0; i < 15; i++)
            send_frame(1, 90, 4, 50);
        wait_idle();
    endtask

    // Counter saturates at its top value and never fires at the top threshold
    task automatic test_counter_saturation();
        apply_config(640, 360, 160, 160, 1, 1, 255, 0);
        for (int i = 0; i < 260; i++)
            send_frame(1, 100, 0, 20);
        wait_idle();
    endtask

    task automatic test_random_frames();
        int tx;
        int ty;
        int mw;
        int mh;
        int mn;
        int cd;
        int n;
        for (int phase = 0; phase < 6; phase++)
        begin
            idle_on = (phase != 2) && (phase < 4);
            case ($urandom_range(0, 5))
                0: tx = 0;
                1: tx = 1279;
                default: tx = $urandom_range(0, 1279);
            endcase
            case ($urandom_range(0, 5))
                0: ty = 0;
                1: ty = 719;
                default: ty = $urandom_range(0, 719);
            endcase
            case ($urandom_range(0, 5))
                0: mw = 0;
                1: mw = 1280;
                default: mw = $urandom_range(40, 300);
            endcase
            case ($urandom_range(0, 5))
                0: mh = 0;
                1: mh = 720;
                default: mh = $urandom_range(40, 300);
            endcase
            case ($urandom_range(0, 5))
                0: mn = 0;
                1: mn = 255;
                default: mn = $urandom_range(0, 6);
            endcase
            case ($urandom_range(0, 5))
                0: cd = 0;
                1: cd = 65535;
                default: cd = $urandom_range(0, 600);
            endcase
            apply_config(tx, ty, mw, mh, $urandom_range(0, 1), $urandom_range(0, 1), mn, cd);
            for (int f = 0; f < 30; f++)
            begin
                n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
                send_frame(n, 60, 6, 700);
                // hold the sender until every result is back
                if (phase == 1 && f == 14)
                    wait_idle();
            end
            wait_idle();
        end
    endtask

    // Result receiver with random back-pressure bursts
    always @(posedge clk)
    begin
        if (!idle_on)
        begin
            ready_hold <= 0;
            out_ready <= 1'b1;
        end
        else if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if ($urandom_range(0, 4) == 0)
        begin
            out_ready <= 1'b0;
            ready_hold <= $urandom_range(1, 10) - 1;
        end
        else
            out_ready <= 1'b1;
    end

    // Compare each result item with the oldest prediction
    always @(posedge clk)
    begin : check_results
        aim_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (aim_expected.size() == 0)
            begin
                $error("unexpected result item: kind %0d x %0d y %0d",
                       out_item.action_kind, out_item.move_x, out_item.move_y);
                err_count++;
            end
            else
            begin
                want = aim_expected.pop_front();
                if (out_item.action_kind !== want.action_kind)
                begin
                    $error("action_kind expected %0d got %0d",
                           want.action_kind, out_item.action_kind);
                    err_count++;
                end
                if (out_item.move_x !== want.move_x)
                begin
                    $error("move_x expected %0d got %0d", want.move_x, out_item.move_x);
                    err_count++;
                end
                if (out_item.move_y !== want.move_y)
                begin
                    $error("move_y expected %0d got %0d", want.move_y, out_item.move_y);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: too long without any item moving on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_TARGET_X;
        cfg_data = '0;
        err_count = 0;
        idle_on = 1'b1;
        ready_hold = 0;
        quiet_cycles = 0;
        clock_ms = '0;
        // reset values of settings and state
        m_target_x = 588;
        m_target_y = 296;
        m_max_w = 110;
        m_max_h = 110;
        m_fire_enable = 1'b0;
        m_track_armed = 1'b1;
        m_min_on = 5;
        m_cooldown = 5000;
        best_valid = 1'b0;
        best_x = 0;
        best_y = 0;
        best_w = 0;
        best_h = 0;
        best_dist = 0;
        on_target = 0;
        last_fire = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_config_extremes();
        test_fire_timing();
        test_counter_saturation();
        test_random_frames();
        wait_idle();

        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
